@@ rtl/core/wfc_pkg.sv @@
// Package for the word frequency counter.
// Holds shared constants, the item function type and the delimiter test.
// No dependencies.
package wfc_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int WORD_CHARS_DEF    = 16;
    localparam int COUNT_W           = 16;

    typedef enum logic [1:0] {
        FUNC_FEED  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    function automatic logic is_delim(input logic [7:0] c);
        case (c)
            8'h20, 8'h0A, 8'h0D, 8'h08, 8'h09, 8'h00: is_delim = 1'b1;
            default: is_delim = 1'b0;
        endcase
    endfunction

endpackage

@@ rtl/core/word_frequency_counter.sv @@
// Top level of the word frequency counter.
// Depends on wfc_pkg and wfc_cell.
//
// Text bytes build a word; a delimiter registers the word and, in the cycle after, a row
// of table cells compares it in parallel, chained by a hit signal so the first match
// wins, then counts it, appends it or, with the table full, drops it. A delimiter that
// ends a word holds off the next item during the compare. A read returns one item through an
// output register, and no further item is accepted while that result item waits.
module word_frequency_counter #(
    parameter int TABLE_ENTRIES = wfc_pkg::TABLE_ENTRIES_DEF,
    parameter int WORD_CHARS    = wfc_pkg::WORD_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], text_byte[9:2], entry_index[15:10], char_position[19:16], zero[23:20]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // word_char[7:0], word_length[12:8], occurrences[28:13], entries_used[35:29],
    // dropped_flag[36], truncated_flag[37], zero[39:38]
    output logic [39:0] m_axis_tdata
);
    localparam int LEN_W = $clog2(WORD_CHARS + 1);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int TOT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int POS_W = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;

    logic [1:0] func;
    logic [7:0] text_byte;
    logic [5:0] entry_index;
    logic [3:0] char_position;
    assign func          = s_axis_tdata[1:0];
    assign text_byte     = s_axis_tdata[9:2];
    assign entry_index   = s_axis_tdata[15:10];
    assign char_position = s_axis_tdata[19:16];

    logic [WORD_CHARS-1:0][7:0] pend_reg;
    logic [LEN_W-1:0]           plen_reg;
    logic [WORD_CHARS-1:0][7:0] cand_reg;
    logic [LEN_W-1:0]           clen_reg;
    logic                       commit_reg;
    logic [TOT_W-1:0]           total_reg;
    logic                       drop_reg, trunc_reg;
    logic                       ovalid_reg;
    logic [39:0]                odata_reg;

    logic [TABLE_ENTRIES:0]                        hit;
    logic [TABLE_ENTRIES-1:0][WORD_CHARS-1:0][7:0] cchars;
    logic [TABLE_ENTRIES-1:0][LEN_W-1:0]           clen;
    logic [TABLE_ENTRIES-1:0][wfc_pkg::COUNT_W-1:0] ccount;
    logic                                          append;

    assign hit[0] = 1'b0;
    assign append = commit_reg && !hit[TABLE_ENTRIES] && total_reg < TOT_W'(TABLE_ENTRIES);

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        wfc_cell #(.WORD_CHARS(WORD_CHARS), .LEN_W(LEN_W)) u_cell (
            .clk(clk),
            .used(TOT_W'(g) < total_reg),
            .commit(commit_reg),
            .write_new(append && total_reg == TOT_W'(g)),
            .cand_chars(cand_reg), .cand_len(clen_reg),
            .hit_in(hit[g]), .hit_out(hit[g+1]),
            .chars(cchars[g]), .len(clen[g]), .count(ccount[g])
        );
    end

    logic accept, out_free;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = !commit_reg && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    logic [IDX_W-1:0] ridx;
    logic             rin;
    logic [7:0]       rch;
    logic [LEN_W-1:0] rlen;
    logic [wfc_pkg::COUNT_W-1:0] rcnt;
    always_comb
    begin
        ridx = IDX_W'(entry_index);
        rin  = {26'd0, entry_index} < 32'(total_reg) && int'(entry_index) < TABLE_ENTRIES;
        rch  = '0;
        rlen = '0;
        rcnt = '0;
        if (rin)
        begin
            rlen = clen[ridx];
            rcnt = ccount[ridx];
            if ({1'b0, char_position} < 5'(rlen) && int'(char_position) < WORD_CHARS)
                rch = cchars[ridx][POS_W'(char_position)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg   <= '0;
            commit_reg <= 1'b0;
            total_reg  <= '0;
            drop_reg   <= 1'b0;
            trunc_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (m_axis_tready)
                ovalid_reg <= 1'b0;
            if (commit_reg)
            begin
                commit_reg <= 1'b0;
                if (append)
                    total_reg <= total_reg + 1'b1;
                else if (!hit[TABLE_ENTRIES])
                    drop_reg <= 1'b1;
            end
            if (accept)
            begin
                case (func)
                    wfc_pkg::FUNC_FEED:
                    begin
                        if (wfc_pkg::is_delim(text_byte))
                        begin
                            if (plen_reg != '0)
                            begin
                                commit_reg <= 1'b1;
                                plen_reg   <= '0;
                            end
                        end
                        else if (plen_reg < LEN_W'(WORD_CHARS))
                            plen_reg <= plen_reg + 1'b1;
                        else
                            trunc_reg <= 1'b1;
                    end
                    wfc_pkg::FUNC_READ:  ovalid_reg <= 1'b1;
                    wfc_pkg::FUNC_CLEAR:
                    begin
                        total_reg <= '0;
                        plen_reg  <= '0;
                        drop_reg  <= 1'b0;
                        trunc_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && func == wfc_pkg::FUNC_FEED)
        begin
            if (wfc_pkg::is_delim(text_byte))
            begin
                cand_reg <= pend_reg;
                clen_reg <= plen_reg;
            end
            else if (plen_reg < LEN_W'(WORD_CHARS))
                pend_reg[POS_W'(plen_reg)] <= text_byte;
        end
        if (accept && func == wfc_pkg::FUNC_READ)
            odata_reg <= {2'b00, trunc_reg, drop_reg, 7'(total_reg), rcnt, 5'(rlen), rch};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule

@@ rtl/core/wfc_cell.sv @@
// One table entry of the word frequency counter.
// Holds one stored word, its length and count; depends on wfc_pkg.
module wfc_cell #(
    parameter int WORD_CHARS = wfc_pkg::WORD_CHARS_DEF,
    parameter int LEN_W      = $clog2(WORD_CHARS + 1)
) (
    input  logic                           clk,
    input  logic                           used,
    input  logic                           commit,
    input  logic                           write_new,
    input  logic [WORD_CHARS-1:0][7:0]     cand_chars,
    input  logic [LEN_W-1:0]               cand_len,
    input  logic                           hit_in,
    output logic                           hit_out,
    output logic [WORD_CHARS-1:0][7:0]     chars,
    output logic [LEN_W-1:0]               len,
    output logic [wfc_pkg::COUNT_W-1:0]    count
);
    logic [WORD_CHARS-1:0][7:0]  chars_reg;
    logic [LEN_W-1:0]            len_reg;
    logic [wfc_pkg::COUNT_W-1:0] count_reg;
    logic                        eq;
    logic                        match;

    always_comb
    begin
        eq = (len_reg == cand_len);
        for (int i = 0; i < WORD_CHARS; i++)
        begin
            if (i < int'(cand_len) && chars_reg[i] != cand_chars[i])
                eq = 1'b0;
        end
    end

    assign match   = used && eq && !hit_in;
    assign hit_out = hit_in || (used && eq);

    always_ff @(posedge clk)
    begin
        if (write_new)
        begin
            chars_reg <= cand_chars;
            len_reg   <= cand_len;
            count_reg <= wfc_pkg::COUNT_W'(1);
        end
        else if (commit && match && count_reg != '1)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    assign chars = chars_reg;
    assign len   = len_reg;
    assign count = count_reg;
endmodule

@@ rtl/core/wfc_checker.sv @@
// Port checker for the word frequency counter.
// Attached by bind to word_frequency_counter; depends on wfc_pkg.
module wfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");
    a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == wfc_pkg::FUNC_READ
        |=> m_axis_tvalid)
        else $error("read gave no result item");
    a_feed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != wfc_pkg::FUNC_READ &&
        !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result item without a read");
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[35:29] <= 7'd64 && m_axis_tdata[12:8] <= 5'd16)
        else $error("result field out of range");
endmodule

bind word_frequency_counter wfc_checker u_wfc_checker (.*);

@@ tb/sv/tb_word_frequency_counter.sv @@
// Testbench for the word frequency counter: text, read and clear items on the input stream.
// A local table model predicts each read result, which is checked against the output stream.
// Depends on wfc_pkg and word_frequency_counter.
module tb_word_frequency_counter;

    localparam int ENTRIES = 64;
    localparam int CHARS   = 16;

    typedef struct packed {
        logic        truncated;
        logic        dropped;
        logic [6:0]  used;
        logic [15:0] cnt;
        logic [4:0]  len;
        logic [7:0]  ch;
    } read_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    logic [7:0]  tbl_chars [ENTRIES][CHARS];
    logic [4:0]  tbl_len [ENTRIES];
    logic [15:0] tbl_cnt [ENTRIES];
    int          tbl_used;
    logic [7:0]  word_buf [CHARS];
    int          word_len;
    logic        drop_flag;
    logic        trunc_flag;

    logic [23:0]  pending_items [$];
    read_result_t expected_reads [$];
    int           errors;
    bit           quiet;
    int           src_gap;
    int           snk_gap;
    bit           feeding_done;

    word_frequency_counter dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit delimiter(input logic [7:0] c);
        return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h08 || c == 8'h09 || c == 8'h00;
    endfunction

    task automatic store_word();
        bit hit;
        hit = 0;
        for (int e = 0; e < tbl_used && !hit; e++)
        begin
            if (tbl_len[e] == word_len)
            begin
                hit = 1;
                for (int i = 0; i < word_len; i++)
                    if (tbl_chars[e][i] != word_buf[i])
                        hit = 0;
                if (hit && tbl_cnt[e] != 16'hFFFF)
                    tbl_cnt[e]++;
            end
        end
        if (!hit)
        begin
            if (tbl_used < ENTRIES)
            begin
                for (int i = 0; i < word_len; i++)
                    tbl_chars[tbl_used][i] = word_buf[i];
                tbl_len[tbl_used] = 5'(word_len);
                tbl_cnt[tbl_used] = 16'd1;
                tbl_used++;
            end
            else
                drop_flag = 1;
        end
    endtask

    task automatic predict_table(input logic [23:0] d);
        wfc_pkg::func_t f;
        logic [7:0]     b;
        int             idx;
        int             pos;
        read_result_t   r;
        f = wfc_pkg::func_t'(d[1:0]);
        b = d[9:2];
        idx = int'(d[15:10]);
        pos = int'(d[19:16]);
        case (f)
            wfc_pkg::FUNC_FEED:
                if (delimiter(b))
                begin
                    if (word_len > 0)
                    begin
                        store_word();
                        word_len = 0;
                    end
                end
                else if (word_len < CHARS)
                    word_buf[word_len++] = b;
                else
                    trunc_flag = 1;
            wfc_pkg::FUNC_READ:
            begin
                r = '0;
                if (idx < tbl_used)
                begin
                    r.len = tbl_len[idx];
                    r.cnt = tbl_cnt[idx];
                    if (pos < tbl_len[idx])
                        r.ch = tbl_chars[idx][pos];
                end
                r.used = 7'(tbl_used);
                r.dropped = drop_flag;
                r.truncated = trunc_flag;
                expected_reads.push_back(r);
            end
            wfc_pkg::FUNC_CLEAR:
            begin
                tbl_used = 0;
                word_len = 0;
                drop_flag = 0;
                trunc_flag = 0;
            end
            default: ;
        endcase
    endtask

    function automatic logic [23:0] pack_item(wfc_pkg::func_t f, logic [7:0] b, int idx,
                                              int pos);
        return {4'b0, pos[3:0], idx[5:0], b, f};
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_items.push_back(pack_item(wfc_pkg::FUNC_FEED, s[i], 0, 0));
    endtask

    // Driver: the prediction runs at acceptance, in item order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_table(s_axis_tdata);
                void'(pending_items.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready)
                ;
            else if (src_gap > 0)
            begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                src_gap       <= $urandom_range(0, 7);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_items[0];
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        read_result_t got;
        read_result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            snk_gap       <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[37:0];
                if (expected_reads.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
                    errors++;
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (got.ch != want.ch || got.len != want.len || got.cnt != want.cnt ||
                        got.used != want.used || got.dropped != want.dropped ||
                        got.truncated != want.truncated || m_axis_tdata[39:38] != 2'b0)
                    begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $realtime, want, m_axis_tdata);
                        errors++;
                    end
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap       <= snk_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                snk_gap       <= $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        string words [8];
        int    n;
        words = '{"a", "ab", "Ab", "xyz", "the", "cat", "abcdefghijklmnopqrs",
                  "abcdefghijklmnopZZ"};
        errors = 0;
        quiet = 0;
        tbl_used = 0;
        word_len = 0;
        drop_flag = 0;
        trunc_flag = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: delimiters, truncation, case, read beyond table, unused code, clear.
        pending_items.push_back(pack_item(wfc_pkg::FUNC_READ, 0, 63, 15));
        push_text("ab Ab\t\tab\nabcdefghijklmnopXY\rabcdefghijklmnopQ");
        pending_items.push_back(pack_item(wfc_pkg::FUNC_FEED, 8'h08, 0, 0));
        pending_items.push_back(pack_item(wfc_pkg::FUNC_FEED, 8'hFF, 0, 0));
        pending_items.push_back(pack_item(wfc_pkg::FUNC_FEED, 8'h00, 0, 0));
        pending_items.push_back(pack_item(wfc_pkg::FUNC_NONE, 8'h41, 0, 0));
        pending_items.push_back(pack_item(wfc_pkg::FUNC_READ, 0, 0, 0));
        pending_items.push_back(pack_item(wfc_pkg::FUNC_READ, 0, 0, 1));
        pending_items.push_back(pack_item(wfc_pkg::FUNC_READ, 0, 2, 15));
        pending_items.push_back(pack_item(wfc_pkg::FUNC_READ, 0, 3, 0));
        pending_items.push_back(pack_item(wfc_pkg::FUNC_READ, 0, 63, 2));
        push_text("tail");
        pending_items.push_back(pack_item(wfc_pkg::FUNC_CLEAR, 0, 0, 0));
        pending_items.push_back(pack_item(wfc_pkg::FUNC_READ, 0, 0, 0));

        // Random: vocabulary sentences, bytes, reads, clears, unused codes, table-filling runs.
        n = 0;
        while (n < 1690)
        begin
            int k;
            int j;
            k = $urandom_range(0, 99);
            if (k < 45)
            begin
                j = $urandom_range(0, 7);
                push_text(words[j]);
                pending_items.push_back(pack_item(wfc_pkg::FUNC_FEED, 8'h20, 0, 0));
                n += words[j].len() + 1;
            end
            else if (k < 60)
            begin
                pending_items.push_back(pack_item(wfc_pkg::FUNC_FEED,
                                                  8'($urandom_range(0, 255)), 0, 0));
                n++;
            end
            else if (k < 62)
            begin
                for (int w = 0; w < 70; w++)
                begin
                    pending_items.push_back(pack_item(wfc_pkg::FUNC_FEED, 8'h41 + w[7:0], 0, 0));
                    pending_items.push_back(pack_item(wfc_pkg::FUNC_FEED, 8'h0A, 0, 0));
                end
                n += 140;
            end
            else if (k < 95)
            begin
                pending_items.push_back(pack_item(wfc_pkg::FUNC_READ, 0, $urandom_range(0, 63),
                                                  $urandom_range(0, 15)));
                n++;
            end
            else if (k < 97)
            begin
                pending_items.push_back(pack_item(wfc_pkg::FUNC_CLEAR, 0, 0, 0));
                n++;
            end
            else
            begin
                pending_items.push_back(pack_item(wfc_pkg::FUNC_NONE,
                                                  8'($urandom_range(0, 255)),
                                                  $urandom_range(0, 63),
                                                  $urandom_range(0, 15)));
                n++;
            end
        end
        pending_items.push_back(pack_item(wfc_pkg::FUNC_READ, 0, 0, 0));
        feeding_done = 1;
    end

    initial
    begin
        wait (feeding_done);
        wait (pending_items.size() < 150);
        quiet = 1;
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_reads.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/wfc_pkg.sv
rtl/core/wfc_cell.sv
rtl/core/word_frequency_counter.sv
rtl/core/wfc_checker.sv
tb/sv/tb_word_frequency_counter.sv
